>>> sv/msdb_pkg.sv
// Shared types and constants for the multisample depth buffer.
// Used by the front end, the command queue, the back end and the top level.
// Depends on nothing else.
package msdb_pkg;

  localparam int PIX_W    = 5;
  localparam int SUB_W    = 3;
  localparam int DEPTH_W  = 32;
  localparam int CHAN_W   = 16;
  localparam int COLOUR_W = 4 * CHAN_W;
  localparam int OUT_W    = 8;
  localparam int LOG2_W   = 2;
  localparam int SW_W     = SUB_W + 1;
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_RESOLVE,
    OP_BLANK
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PIX_W-1:0]    px;
    logic [PIX_W-1:0]    py;
    logic [SUB_W-1:0]    sx;
    logic [SUB_W-1:0]    sy;
    logic [DEPTH_W-1:0]  depth;
    logic [COLOUR_W-1:0] colour;
  } cmd_t;

  // Effective subsamples per pixel side: 1 << log2, capped at the layout maximum.
  function automatic logic [SW_W-1:0] sub_width(logic [LOG2_W-1:0] log2, int max_sw);
    int sw;
    sw = 1 << log2;
    if (sw > max_sw) begin
      sw = max_sw;
    end
    return SW_W'(sw);
  endfunction

endpackage

>>> sv/msdb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing else.
module msdb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> sv/msdb_front.sv
// Front end: accepts items and sorts them into writes, resolves and blank resolves.
// Writes outside the pixel grid or the active subsample square are dropped here.
// Depends on msdb_pkg.
module msdb_front #(
  parameter int MAX_WIDTH     = 32,
  parameter int MAX_HEIGHT    = 32,
  parameter int MAX_SUB_WIDTH = 8
) (
  input  logic [msdb_pkg::LOG2_W-1:0]  sub_width_log2_i,
  input  logic                         push_i,
  input  logic                         cmd_i,
  input  logic [msdb_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [msdb_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic [msdb_pkg::SUB_W-1:0]   sub_x_i,
  input  logic [msdb_pkg::SUB_W-1:0]   sub_y_i,
  input  logic [msdb_pkg::DEPTH_W-1:0] depth_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  red_in_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  green_in_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  blue_in_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  alpha_in_i,
  input  logic                         fifo_full_i,
  input  logic                         clear_busy_i,
  output logic                         full_o,
  output logic                         fifo_push_o,
  output msdb_pkg::cmd_t               fifo_cmd_o
);

  logic                        pix_ok;
  logic                        sub_ok;
  logic [msdb_pkg::SW_W-1:0]   sw;

  assign sw     = msdb_pkg::sub_width(sub_width_log2_i, MAX_SUB_WIDTH);
  assign pix_ok = (int'(pixel_x_i) < MAX_WIDTH) && (int'(pixel_y_i) < MAX_HEIGHT);
  assign sub_ok = ({1'b0, sub_x_i} < sw) && ({1'b0, sub_y_i} < sw);

  // The queue is closed while the stores are being cleared after reset.
  assign full_o = fifo_full_i | clear_busy_i;

  always_comb begin
    fifo_cmd_o.px     = pixel_x_i;
    fifo_cmd_o.py     = pixel_y_i;
    fifo_cmd_o.sx     = sub_x_i;
    fifo_cmd_o.sy     = sub_y_i;
    fifo_cmd_o.depth  = depth_i;
    fifo_cmd_o.colour = {alpha_in_i, blue_in_i, green_in_i, red_in_i};
    if (cmd_i) begin
      fifo_cmd_o.op = pix_ok ? msdb_pkg::OP_RESOLVE : msdb_pkg::OP_BLANK;
      fifo_push_o   = push_i & ~full_o;
    end else begin
      fifo_cmd_o.op = msdb_pkg::OP_WRITE;
      fifo_push_o   = push_i & ~full_o & pix_ok & sub_ok;
    end
  end

endmodule

>>> sv/msdb_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on msdb_pkg for the command type and the queue depth.
module msdb_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  msdb_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output msdb_pkg::cmd_t head_o
);

  localparam int PTR_W = $clog2(msdb_pkg::CMDQ_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  msdb_pkg::cmd_t   entry_q [msdb_pkg::CMDQ_DEPTH];
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(msdb_pkg::CMDQ_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i);
    count_d  = count_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> sv/msdb_back.sv
// Back end: clears the stores after reset, then runs depth-tested writes as a
// read-modify-write and resolves as a walk over the active subsamples.
// Depends on msdb_pkg and msdb_ram.
module msdb_back #(
  parameter int MAX_WIDTH     = 32,
  parameter int MAX_HEIGHT    = 32,
  parameter int MAX_SUB_WIDTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [msdb_pkg::LOG2_W-1:0] sub_width_log2_i,
  input  logic                        fifo_empty_i,
  input  msdb_pkg::cmd_t              fifo_head_i,
  output logic                        fifo_pop_o,
  output logic                        clear_busy_o,
  input  logic                        pop_i,
  output logic                        out_valid_o,
  output logic [msdb_pkg::OUT_W-1:0]  red_o,
  output logic [msdb_pkg::OUT_W-1:0]  green_o,
  output logic [msdb_pkg::OUT_W-1:0]  blue_o
);

  localparam int SPP         = MAX_SUB_WIDTH * MAX_SUB_WIDTH;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * SPP;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SUM_W       = msdb_pkg::CHAN_W + 2 * $clog2(MAX_SUB_WIDTH);
  localparam int CW          = msdb_pkg::CHAN_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_CMP,
    ST_RES,
    ST_RES_LAST
  } state_e;

  function automatic logic [ADDR_W-1:0] sample_addr(
    logic [msdb_pkg::PIX_W-1:0] px,
    logic [msdb_pkg::PIX_W-1:0] py,
    logic [msdb_pkg::SUB_W-1:0] sx,
    logic [msdb_pkg::SUB_W-1:0] sy
  );
    int a;
    a = (int'(py) * MAX_WIDTH + int'(px)) * SPP + int'(sy) * MAX_SUB_WIDTH + int'(sx);
    return ADDR_W'(a);
  endfunction

  state_e                        state_q;
  logic [ADDR_W-1:0]             clr_q;
  msdb_pkg::cmd_t                cur_q;
  logic [ADDR_W-1:0]             wr_addr_q;
  logic [msdb_pkg::SUB_W-1:0]    sx_q;
  logic [msdb_pkg::SUB_W-1:0]    sy_q;
  logic                          acc_q;
  logic [SUM_W-1:0]              sum_r_q, sum_g_q, sum_b_q;
  logic                          out_valid_q;
  logic [msdb_pkg::OUT_W-1:0]    red_q, green_q, blue_q;

  logic [msdb_pkg::SW_W-1:0]     sw;
  logic [3:0]                    shamt;
  logic                          last_x, last_y;
  logic [ADDR_W-1:0]             head_addr;
  logic [SUM_W-1:0]              fin_r, fin_g, fin_b;

  logic                          dep_we, dep_re;
  logic [ADDR_W-1:0]             dep_waddr, dep_raddr;
  logic [msdb_pkg::DEPTH_W-1:0]  dep_wdata, dep_rdata;
  logic                          col_we, col_re;
  logic [ADDR_W-1:0]             col_waddr, col_raddr;
  logic [msdb_pkg::COLOUR_W-1:0] col_wdata, col_rdata;
  logic                          hit;

  assign sw        = msdb_pkg::sub_width(sub_width_log2_i, MAX_SUB_WIDTH);
  assign shamt     = {1'b0, sub_width_log2_i, 1'b0} + 4'd8;
  assign last_x    = ({1'b0, sx_q} + msdb_pkg::SW_W'(1)) == sw;
  assign last_y    = ({1'b0, sy_q} + msdb_pkg::SW_W'(1)) == sw;
  assign head_addr = sample_addr(fifo_head_i.px, fifo_head_i.py,
                                 fifo_head_i.sx, fifo_head_i.sy);

  // A resolve or blank resolve may only start when the result register is free; writes never wait for it.
  assign fifo_pop_o = (state_q == ST_IDLE) && !fifo_empty_i &&
                      ((fifo_head_i.op == msdb_pkg::OP_WRITE) || !out_valid_q);
  assign clear_busy_o = (state_q == ST_CLEAR);

  assign hit       = (state_q == ST_WR_CMP) && (cur_q.depth <= dep_rdata);
  assign dep_we    = clear_busy_o || hit;
  assign dep_waddr = clear_busy_o ? clr_q : wr_addr_q;
  assign dep_wdata = clear_busy_o ? '1 : cur_q.depth;
  assign dep_re    = fifo_pop_o && (fifo_head_i.op == msdb_pkg::OP_WRITE);
  assign dep_raddr = head_addr;

  assign col_we    = dep_we;
  assign col_waddr = dep_waddr;
  assign col_wdata = clear_busy_o ? '0 : cur_q.colour;
  assign col_re    = (state_q == ST_RES);
  assign col_raddr = sample_addr(cur_q.px, cur_q.py, sx_q, sy_q);

  // The last subsample arrives in the final cycle and is folded in here.
  assign fin_r = sum_r_q + SUM_W'(col_rdata[CW-1:0]);
  assign fin_g = sum_g_q + SUM_W'(col_rdata[2*CW-1:CW]);
  assign fin_b = sum_b_q + SUM_W'(col_rdata[3*CW-1:2*CW]);

  msdb_ram #(.WIDTH(msdb_pkg::DEPTH_W), .DEPTH(STORE_DEPTH)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .re_i    (dep_re),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  msdb_ram #(.WIDTH(msdb_pkg::COLOUR_W), .DEPTH(STORE_DEPTH)) u_colour_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .re_i    (col_re),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_q       <= '0;
      wr_addr_q   <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      acc_q       <= 1'b0;
      sum_r_q     <= '0;
      sum_g_q     <= '0;
      sum_b_q     <= '0;
      out_valid_q <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      acc_q <= (state_q == ST_RES);
      if (acc_q) begin
        sum_r_q <= fin_r;
        sum_g_q <= fin_g;
        sum_b_q <= fin_b;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (fifo_pop_o) begin
            cur_q <= fifo_head_i;
            unique case (fifo_head_i.op)
              msdb_pkg::OP_WRITE: begin
                wr_addr_q <= head_addr;
                state_q   <= ST_WR_CMP;
              end
              msdb_pkg::OP_RESOLVE: begin
                sx_q    <= '0;
                sy_q    <= '0;
                sum_r_q <= '0;
                sum_g_q <= '0;
                sum_b_q <= '0;
                state_q <= ST_RES;
              end
              msdb_pkg::OP_BLANK: begin
                red_q       <= '0;
                green_q     <= '0;
                blue_q      <= '0;
                out_valid_q <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_WR_CMP: begin
          state_q <= ST_IDLE;
        end
        ST_RES: begin
          if (last_x && last_y) begin
            state_q <= ST_RES_LAST;
          end else if (last_x) begin
            sx_q <= '0;
            sy_q <= sy_q + msdb_pkg::SUB_W'(1);
          end else begin
            sx_q <= sx_q + msdb_pkg::SUB_W'(1);
          end
        end
        ST_RES_LAST: begin
          red_q       <= msdb_pkg::OUT_W'(fin_r >> shamt);
          green_q     <= msdb_pkg::OUT_W'(fin_g >> shamt);
          blue_q      <= msdb_pkg::OUT_W'(fin_b >> shamt);
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |-> !fifo_empty_i)
    else $error("command popped from an empty queue");

  a_store_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dep_we |-> (state_q == ST_CLEAR) || (state_q == ST_WR_CMP))
    else $error("store written outside clearing or a depth-test cycle");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RES_LAST) ||
      $past(fifo_pop_o && (fifo_head_i.op == msdb_pkg::OP_BLANK)))
    else $error("result appeared without a finished resolve");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop_i) |=> out_valid_q && $stable(red_q) && $stable(blue_q))
    else $error("waiting result lost or changed");

endmodule

>>> sv/multisample_depth_buffer_top.sv
// Top level of the multisample depth buffer: configuration register, front end,
// command queue and back end. Depends on msdb_pkg, msdb_front, msdb_cmd_fifo, msdb_back.
//
//   channel   handshake            payload
//   input     push / full          cmd_i, pixel_x_i, pixel_y_i, sub_x_i, sub_y_i,
//                                   depth_i, red_in_i, green_in_i, blue_in_i, alpha_in_i
//   result    empty / pop          red_out_o, green_out_o, blue_out_o
//   config    cfg_we_i             cfg_data_i (sub_width_log2)
//
// A kept write occupies the back end for a store read, then a compare and write.
// A resolve walks the sw*sw active subsamples, where sw is the active subsample width; the walk
// reads one subsample per cycle from the colour memory. Blank resolves return zeros.
// After reset both stores are cleared, one entry a cycle, over all
// MAX_WIDTH*MAX_HEIGHT*MAX_SUB_WIDTH^2 entries (65536 by default); full is high meanwhile.
// Full rises when the two-entry command queue fills; a waiting result stalls resolves.
module multisample_depth_buffer_top #(
  parameter int MAX_WIDTH     = 32,
  parameter int MAX_HEIGHT    = 32,
  parameter int MAX_SUB_WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [msdb_pkg::LOG2_W-1:0]  cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic                         cmd_i,
  input  logic [msdb_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [msdb_pkg::PIX_W-1:0]   pixel_y_i,
  input  logic [msdb_pkg::SUB_W-1:0]   sub_x_i,
  input  logic [msdb_pkg::SUB_W-1:0]   sub_y_i,
  input  logic [msdb_pkg::DEPTH_W-1:0] depth_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  red_in_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  green_in_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  blue_in_i,
  input  logic [msdb_pkg::CHAN_W-1:0]  alpha_in_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [msdb_pkg::OUT_W-1:0]   red_out_o,
  output logic [msdb_pkg::OUT_W-1:0]   green_out_o,
  output logic [msdb_pkg::OUT_W-1:0]   blue_out_o
);

  logic [msdb_pkg::LOG2_W-1:0] sub_width_log2_q;
  logic                        fifo_full, fifo_empty, fifo_push, fifo_pop;
  logic                        clear_busy, out_valid;
  msdb_pkg::cmd_t              fifo_cmd, fifo_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_width_log2_q <= '0;
    end else if (cfg_we_i) begin
      sub_width_log2_q <= cfg_data_i;
    end
  end

  msdb_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .MAX_SUB_WIDTH (MAX_SUB_WIDTH)
  ) u_front (
    .sub_width_log2_i (sub_width_log2_q),
    .push_i           (push),
    .cmd_i            (cmd_i),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .sub_x_i          (sub_x_i),
    .sub_y_i          (sub_y_i),
    .depth_i          (depth_i),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .alpha_in_i       (alpha_in_i),
    .fifo_full_i      (fifo_full),
    .clear_busy_i     (clear_busy),
    .full_o           (full),
    .fifo_push_o      (fifo_push),
    .fifo_cmd_o       (fifo_cmd)
  );

  msdb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .cmd_i   (fifo_cmd),
    .pop_i   (fifo_pop),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .head_o  (fifo_head)
  );

  msdb_back #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .MAX_SUB_WIDTH (MAX_SUB_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sub_width_log2_i (sub_width_log2_q),
    .fifo_empty_i     (fifo_empty),
    .fifo_head_i      (fifo_head),
    .fifo_pop_o       (fifo_pop),
    .clear_busy_o     (clear_busy),
    .pop_i            (pop),
    .out_valid_o      (out_valid),
    .red_o            (red_out_o),
    .green_o          (green_out_o),
    .blue_o           (blue_out_o)
  );

  assign empty = ~out_valid;

endmodule
